FILE: hdl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg: shared types and constants for the pulse width capture block
// Item, result and measurement state records used by the top level and the
// update logic.
// ----------------------------------------------------------------------------
package pwc_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int OVF_WIDTH   = 16;
   localparam int PULSE_WIDTH = 32;

   localparam logic [OVF_WIDTH-1:0] OVF_MAX = {OVF_WIDTH{1'b1}};

   typedef struct packed {
      logic                   overflow_event;
      logic                   capture_event;
      logic [VALUE_WIDTH-1:0] latched_value;
      logic [VALUE_WIDTH-1:0] counter_now;
      logic                   acknowledge;
   } item_type;

   typedef struct packed {
      logic [OVF_WIDTH-1:0]   overflow_count;
      logic [VALUE_WIDTH-1:0] start_value;
      logic [PULSE_WIDTH-1:0] measured_width;
      logic                   edge_select;
      logic                   valid_flag;
      logic                   overwrite_flag;
   } state_type;

   typedef struct packed {
      logic [PULSE_WIDTH-1:0] pulse_width;
      logic                   width_valid;
      logic                   width_overwritten;
      logic                   await_falling;
      logic                   width_done;
   } result_type;

endpackage

FILE: hdl/pwc_update.sv
// ----------------------------------------------------------------------------
// pwc_update: measurement state update for one item
// Applies acknowledge, overflow counting and the edge capture to the stored
// state and forms the result item.
// ----------------------------------------------------------------------------
module pwc_update #(
   parameter int COUNTER_WIDTH = 16
) (
   input  pwc_pkg::item_type   item,
   input  pwc_pkg::state_type  state_cur,
   output pwc_pkg::state_type  state_nxt,
   output pwc_pkg::result_type result
);
   import pwc_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] CNT_MASK = (COUNTER_WIDTH >= VALUE_WIDTH) ?
      {VALUE_WIDTH{1'b1}} : VALUE_WIDTH'((64'd1 << COUNTER_WIDTH) - 64'd1);

   logic [VALUE_WIDTH-1:0] cval;
   logic [VALUE_WIDTH-1:0] now;
   logic                   early;
   logic [OVF_WIDTH-1:0]   ovf_inc;
   logic [OVF_WIDTH-1:0]   ovf_end;
   logic [63:0]            width_full;
   logic                   valid_ack;
   logic                   over_ack;
   logic                   done;

   assign cval  = item.latched_value & CNT_MASK;
   assign now   = item.counter_now & CNT_MASK;
   assign early = item.overflow_event && (cval > now);

   assign ovf_inc = (item.overflow_event && state_cur.overflow_count != OVF_MAX) ?
                    state_cur.overflow_count + 1'b1 : state_cur.overflow_count;
   assign ovf_end = early ? ovf_inc - 1'b1 : ovf_inc;

   assign width_full = (64'(ovf_end) << COUNTER_WIDTH) + 64'(cval) - 64'(state_cur.start_value);

   assign valid_ack = state_cur.valid_flag && !item.acknowledge;
   assign over_ack  = state_cur.overwrite_flag && !item.acknowledge;

   always_comb begin
      state_nxt                = state_cur;
      state_nxt.valid_flag     = valid_ack;
      state_nxt.overwrite_flag = over_ack;
      state_nxt.overflow_count = ovf_inc;
      done                     = 1'b0;
      if (item.capture_event) begin
         if (!state_cur.edge_select) begin
            state_nxt.overflow_count = early ? OVF_WIDTH'(1) : '0;
            state_nxt.start_value    = cval;
            state_nxt.edge_select    = 1'b1;
         end else begin
            state_nxt.overflow_count = ovf_end;
            state_nxt.measured_width = width_full[PULSE_WIDTH-1:0];
            if (valid_ack) begin
               state_nxt.overwrite_flag = 1'b1;
            end else begin
               state_nxt.valid_flag = 1'b1;
            end
            state_nxt.edge_select = 1'b0;
            done                  = 1'b1;
         end
      end
   end

   assign result.pulse_width       = state_nxt.measured_width;
   assign result.width_valid       = state_nxt.valid_flag;
   assign result.width_overwritten = state_nxt.overwrite_flag;
   assign result.await_falling     = state_nxt.edge_select;
   assign result.width_done        = done;

endmodule

FILE: hdl/pulse_width_capture.sv
// ----------------------------------------------------------------------------
// pulse_width_capture: high-pulse width measurement on a free-running timer
// Counts timer overflows and turns rising/falling capture pairs into widths.
//
// Usage: each req item carries the overflow and capture events of one timer
// handling step, the captured and current counter values and an acknowledge
// bit that clears the valid and overwrite flags before the item is applied.
// Each req item yields exactly one rsp item with the last measured width and
// the flags after that item; width_done marks an item that ended a pulse.
// An accepted item sits in the input register and moves into the result
// register once that register is empty or being read, and rsp_tvalid rises
// when the item is there. Throughput is one item per cycle unless the
// receiver stalls, set by the single update step between the input
// register and the result register.
// Reset clears the measurement state (waiting for a rising edge, no width)
// and empties both registers. When the receiver stalls, the result register
// holds its item and the input register takes one more; req_tready then
// falls until rsp_tready returns.
// ----------------------------------------------------------------------------
module pulse_width_capture #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // latched_value[15:0], counter_now[31:16]
   input  logic [2:0]  req_tuser,  // overflow_event[0], capture_event[1], acknowledge[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // pulse_width[31:0]
   output logic [3:0]  rsp_tuser   // width_valid[0], width_overwritten[1],
                                   // await_falling[2], width_done[3]
);
   import pwc_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_result_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   pwc_update #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_update (
      .item     (in_item_ff),
      .state_cur(state_ff),
      .state_nxt(state_in),
      .result   (result_in)
   );

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.overflow_event <= req_tuser[0];
         in_item_ff.capture_event  <= req_tuser[1];
         in_item_ff.acknowledge    <= req_tuser[2];
         in_item_ff.latched_value  <= req_tdata[15:0];
         in_item_ff.counter_now    <= req_tdata[31:16];
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_result_ff.pulse_width;
   assign rsp_tuser[0] = out_result_ff.width_valid;
   assign rsp_tuser[1] = out_result_ff.width_overwritten;
   assign rsp_tuser[2] = out_result_ff.await_falling;
   assign rsp_tuser[3] = out_result_ff.width_done;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      state_ff.overwrite_flag |-> state_ff.valid_flag)
      else $error("overwrite flag set without valid flag");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[0] && !rsp_tuser[2])
      else $error("finished measurement without valid flag or still awaiting falling edge");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("item taken while both registers are full and stalled");

   assert property (@(posedge clock) disable iff (reset)
      !advance |=> state_ff == $past(state_ff))
      else $error("measurement state changed without an item moving to the output");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for pulse_width_capture
// Sends timer event items into the block and keeps its own copy of the
// overflow count, edge tracking and width arithmetic. Every result item is
// compared field by field. A directed table covers the corner cases, two
// overflow runs stretch pulses across many timer wraps, and random items
// follow with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import pwc_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 640;
   localparam int OVERFLOW_RUN = 24;

   typedef struct {
      item_type   stim;
      bit         fixed;
      result_type want;
   } row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   state_type   pulse_state = '0;
   result_type  width_queue[$];
   row_type     directed[$];
   bit          idle_on         = 1'b1;
   int          mismatch_count  = 0;
   int          items_sent      = 0;
   int          results_checked = 0;
   int          widths_done     = 0;
   int          stall_cycles    = 0;

   pulse_width_capture DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Acknowledge first, then the overflow, then the capture.
   function automatic result_type step_pulse(item_type stim);
      result_type             res;
      logic                   early;
      logic [PULSE_WIDTH-1:0] span;
      res.width_done = 1'b0;
      if (stim.acknowledge) begin
         pulse_state.valid_flag     = 1'b0;
         pulse_state.overwrite_flag = 1'b0;
      end
      if (stim.overflow_event && pulse_state.overflow_count != OVF_MAX) begin
         pulse_state.overflow_count = pulse_state.overflow_count + 1'b1;
      end
      if (stim.capture_event) begin
         early = stim.overflow_event && (stim.latched_value > stim.counter_now);
         if (!pulse_state.edge_select) begin
            pulse_state.overflow_count = early ? OVF_WIDTH'(1) : '0;
            pulse_state.start_value    = stim.latched_value;
            pulse_state.edge_select    = 1'b1;
         end else begin
            if (early) begin
               pulse_state.overflow_count = pulse_state.overflow_count - 1'b1;
            end
            span = {pulse_state.overflow_count, {VALUE_WIDTH{1'b0}}};
            span = span + stim.latched_value - pulse_state.start_value;
            pulse_state.measured_width = span;
            if (pulse_state.valid_flag) begin
               pulse_state.overwrite_flag = 1'b1;
            end else begin
               pulse_state.valid_flag = 1'b1;
            end
            pulse_state.edge_select = 1'b0;
            res.width_done          = 1'b1;
         end
      end
      res.pulse_width       = pulse_state.measured_width;
      res.width_valid       = pulse_state.valid_flag;
      res.width_overwritten = pulse_state.overwrite_flag;
      res.await_falling     = pulse_state.edge_select;
      return res;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return VALUE_WIDTH'($urandom);
         end
      endcase
   endfunction

   function automatic item_type random_item();
      item_type stim;
      stim.overflow_event = ($urandom_range(99) < 30);
      stim.capture_event  = ($urandom_range(99) < 35);
      stim.acknowledge    = ($urandom_range(99) < 15);
      stim.latched_value  = pick_value();
      stim.counter_now    = pick_value();
      return stim;
   endfunction

   function automatic item_type overflow_item();
      item_type stim;
      stim.overflow_event = 1'b1;
      stim.capture_event  = 1'b0;
      stim.acknowledge    = 1'($urandom_range(1));
      stim.latched_value  = VALUE_WIDTH'($urandom);
      stim.counter_now    = VALUE_WIDTH'($urandom);
      return stim;
   endfunction

   task automatic table_row(input logic ovf, cap, ack, input logic [15:0] cval, now,
                            input bit fixed, input logic [31:0] width,
                            input logic valid, ovw, falling, done);
      row_type row;
      row.stim.overflow_event      = ovf;
      row.stim.capture_event       = cap;
      row.stim.acknowledge         = ack;
      row.stim.latched_value       = cval;
      row.stim.counter_now         = now;
      row.fixed                    = fixed;
      row.want.pulse_width         = width;
      row.want.width_valid         = valid;
      row.want.width_overwritten   = ovw;
      row.want.await_falling       = falling;
      row.want.width_done          = done;
      directed.push_back(row);
   endtask

   // The handshake inputs only change at rising edges, so the level seen at
   // the falling edge is the one the next rising edge acts on.
   task automatic send_item(input item_type stim, input bit fixed, input result_type want);
      result_type model;
      while (idle_on && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stim.counter_now, stim.latched_value};
      req_tuser  <= {stim.acknowledge, stim.capture_event, stim.overflow_event};
      @(negedge clock);
      while (!req_tready) begin
         @(negedge clock);
      end
      @(posedge clock);
      model = step_pulse(stim);
      width_queue.push_back(fixed ? want : model);
      items_sent++;
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         report_mismatch($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                   results_checked, name, want, got));
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (width_queue.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      results_checked));
         end else begin
            want = width_queue.pop_front();
            check_field("pulse_width", 64'(want.pulse_width), 64'(rsp_tdata));
            check_field("width_valid", 64'(want.width_valid), 64'(rsp_tuser[0]));
            check_field("width_overwritten", 64'(want.width_overwritten),
                        64'(rsp_tuser[1]));
            check_field("await_falling", 64'(want.await_falling), 64'(rsp_tuser[2]));
            check_field("width_done", 64'(want.width_done), 64'(rsp_tuser[3]));
            if (want.width_done) begin
               widths_done++;
            end
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      item_type   stim;
      result_type none;
      none = '0;
      //        ovf cap ack cval      now       fix width          v  o  f  d
      table_row(0,  0,  0,  16'hFFFF, 16'hFFFF, 1,  32'h0000_0000, 0, 0, 0, 0);
      table_row(0,  1,  0,  16'h0010, 16'h0020, 1,  32'h0000_0000, 0, 0, 1, 0);
      table_row(0,  1,  0,  16'h0015, 16'h0000, 1,  32'h0000_0005, 1, 0, 0, 1);
      table_row(0,  1,  0,  16'hFFFF, 16'h0000, 1,  32'h0000_0005, 1, 0, 1, 0);
      table_row(0,  1,  0,  16'h0000, 16'h0000, 1,  32'hFFFF_0001, 1, 1, 0, 1);
      table_row(0,  0,  1,  16'h0000, 16'h0000, 1,  32'hFFFF_0001, 0, 0, 0, 0);
      table_row(1,  1,  0,  16'hFFF0, 16'h0005, 1,  32'hFFFF_0001, 0, 0, 1, 0);
      table_row(1,  0,  0,  16'h0000, 16'h0000, 1,  32'hFFFF_0001, 0, 0, 1, 0);
      table_row(1,  1,  0,  16'hFFFE, 16'h0001, 1,  32'h0002_000E, 1, 0, 0, 1);
      table_row(1,  1,  1,  16'h0003, 16'h0004, 1,  32'h0002_000E, 0, 0, 1, 0);
      table_row(1,  1,  0,  16'h0002, 16'h0009, 1,  32'h0000_FFFF, 1, 0, 0, 1);
      table_row(1,  1,  0,  16'h8000, 16'h8000, 1,  32'h0000_FFFF, 1, 0, 1, 0);
      table_row(0,  1,  1,  16'h0000, 16'h1234, 1,  32'hFFFF_8000, 1, 0, 0, 1);
      table_row(1,  1,  0,  16'hFFFF, 16'h0000, 1,  32'hFFFF_8000, 1, 0, 1, 0);
      table_row(1,  1,  0,  16'hFFFF, 16'hFFFE, 1,  32'h0001_0000, 1, 1, 0, 1);
      table_row(1,  0,  1,  16'hFFFF, 16'hFFFF, 1,  32'h0001_0000, 0, 0, 0, 0);
      table_row(0,  1,  0,  16'h1357, 16'h2000, 0,  32'h0,         0, 0, 0, 0);
      table_row(1,  1,  0,  16'hA5A5, 16'h5A5A, 0,  32'h0,         0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_item(directed[i].stim, directed[i].fixed, directed[i].want);
      end

      // Let the overflow count climb over a run of overflows, then close the
      // pulse once normally and once with the capture ahead of the overflow.
      idle_on = 1'b0;
      for (int round = 0; round < 2; round++) begin
         stim                = random_item();
         stim.overflow_event = 1'b0;
         stim.capture_event  = 1'b1;
         send_item(stim, 1'b0, none);
         repeat (OVERFLOW_RUN) send_item(overflow_item(), 1'b0, none);
         stim                = random_item();
         stim.overflow_event = (round == 1);
         stim.capture_event  = 1'b1;
         stim.latched_value  = 16'hFFFF;
         stim.counter_now    = 16'h0000;
         send_item(stim, 1'b0, none);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = (n < 240) || (n >= 400);
         if ($urandom_range(99) < 4) begin
            repeat ($urandom_range(8, 2)) send_item(overflow_item(), 1'b0, none);
         end
         send_item(random_item(), 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (width_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d items and checked %0d results, %0d of them finished a pulse.",
               items_sent, results_checked, widths_done);
      $display("Covered early captures, acknowledges, wrapped widths and overflow runs.");
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/pwc_pkg.sv
hdl/pwc_update.sv
hdl/pulse_width_capture.sv
tb/sv/tb_top.sv
